@@ sv/e2q_pkg.sv @@
`default_nettype none

package e2q_pkg;

   localparam int CORDIC_ITERS  = 30;
   localparam int INT_FRAC      = 30;
   localparam int OUT_FRAC_BITS = 14;
   localparam int PROD_STAGES   = 4;
   localparam int LATENCY       = CORDIC_ITERS + PROD_STAGES;

   localparam int OUT_SHIFT = INT_FRAC - OUT_FRAC_BITS;
   localparam logic signed [34:0] OUT_ROUND =
      (OUT_SHIFT > 0) ? (35'sd1 <<< (OUT_SHIFT - 1)) : 35'sd0;
   localparam logic signed [34:0] OUT_ONE = 35'sd1 <<< OUT_FRAC_BITS;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;
   localparam int LANES      = 3;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [33:0] z;
   } e2q_vec_type;

   typedef e2q_vec_type [LANES-1:0] e2q_lanes_type;

   // atan(2^-i), 2^32 = one turn
   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] a;
      case (i)
         5'd0:  a = 34'sh020000000;
         5'd1:  a = 34'sh012E4051E;
         5'd2:  a = 34'sh009FB385B;
         5'd3:  a = 34'sh0051111D4;
         5'd4:  a = 34'sh0028B0D43;
         5'd5:  a = 34'sh00145D7E1;
         5'd6:  a = 34'sh000A2F61E;
         5'd7:  a = 34'sh000517C55;
         5'd8:  a = 34'sh00028BE53;
         5'd9:  a = 34'sh000145F2F;
         5'd10: a = 34'sh0000A2F98;
         5'd11: a = 34'sh0000517CC;
         5'd12: a = 34'sh000028BE6;
         5'd13: a = 34'sh0000145F3;
         5'd14: a = 34'sh00000A2FA;
         5'd15: a = 34'sh00000517D;
         5'd16: a = 34'sh0000028BE;
         5'd17: a = 34'sh00000145F;
         5'd18: a = 34'sh000000A30;
         5'd19: a = 34'sh000000518;
         5'd20: a = 34'sh00000028C;
         5'd21: a = 34'sh000000146;
         5'd22: a = 34'sh0000000A3;
         5'd23: a = 34'sh000000051;
         5'd24: a = 34'sh000000029;
         5'd25: a = 34'sh000000014;
         5'd26: a = 34'sh00000000A;
         5'd27: a = 34'sh000000005;
         5'd28: a = 34'sh000000003;
         5'd29: a = 34'sh000000001;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

@@ sv/e2q_cell.sv @@
`default_nettype none

module e2q_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [4:0]             idx,
   input  wire logic                   valid_in,
   input  wire e2q_pkg::e2q_lanes_type lanes_in,
   output logic                        valid_out,
   output e2q_pkg::e2q_lanes_type      lanes_out
);
   import e2q_pkg::*;

   logic          valid_ff;
   e2q_lanes_type lanes_ff;
   e2q_lanes_type lanes_in_next;

   always_comb begin
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [33:0] z;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [33:0] a;
      a = atan_turn(idx);
      for (int l = 0; l < LANES; l++) begin
         x  = lanes_in[l].x;
         y  = lanes_in[l].y;
         z  = lanes_in[l].z;
         dx = y >>> idx;
         dy = x >>> idx;
         if (!z[33]) begin
            lanes_in_next[l].x = x - dx;
            lanes_in_next[l].y = y + dy;
            lanes_in_next[l].z = z - a;
         end else begin
            lanes_in_next[l].x = x + dx;
            lanes_in_next[l].y = y - dy;
            lanes_in_next[l].z = z + a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in_next;
   end

   assign valid_out = valid_ff;
   assign lanes_out = lanes_ff;

endmodule

`default_nettype wire

@@ sv/e2q_prod.sv @@
`default_nettype none

module e2q_prod (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_in,
   input  wire e2q_pkg::e2q_lanes_type lanes_in,
   output logic                        valid_out,
   output logic signed [15:0]          quat_w,
   output logic signed [15:0]          quat_slot_x,
   output logic signed [15:0]          quat_slot_y,
   output logic signed [15:0]          quat_slot_z
);
   import e2q_pkg::*;

   function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                  input logic signed [31:0] b);
      logic signed [64:0] p;
      logic signed [65:0] r;
      p = a * b;
      r = {p[64], p} + (66'sd1 <<< (INT_FRAC - 1));
      r = r >>> INT_FRAC;
      return r[32:0];
   endfunction

   function automatic logic [15:0] to_out(input logic signed [33:0] v);
      logic signed [34:0] r;
      r = {v[33], v} + OUT_ROUND;
      r = r >>> OUT_SHIFT;
      if (r > OUT_ONE) begin
         r = OUT_ONE;
      end
      if (r < -OUT_ONE) begin
         r = -OUT_ONE;
      end
      return r[15:0];
   endfunction

   logic [PROD_STAGES-1:0] valid_ff;

   logic signed [31:0] cy, sy, cp, sp, cr, sr;

   logic signed [32:0] p_cc_ff, p_ss_ff, p_sc_ff, p_cs_ff;
   logic signed [31:0] cy1_ff, sy1_ff;

   logic signed [32:0] t_xa_ff, t_xb_ff, t_ya_ff, t_yb_ff;
   logic signed [32:0] t_za_ff, t_zb_ff, t_wa_ff, t_wb_ff;

   logic signed [33:0] qw_ff, qx_ff, qy_ff, qz_ff;

   logic [15:0] out_w_ff, out_x_ff, out_y_ff, out_z_ff;

   assign cy = lanes_in[LANE_YAW].x;
   assign sy = lanes_in[LANE_YAW].y;
   assign cp = lanes_in[LANE_PITCH].x;
   assign sp = lanes_in[LANE_PITCH].y;
   assign cr = lanes_in[LANE_ROLL].x;
   assign sr = lanes_in[LANE_ROLL].y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[PROD_STAGES-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      // roll-pitch pairs
      p_cc_ff <= mul_q30(33'(cr), cp);
      p_ss_ff <= mul_q30(33'(sr), sp);
      p_sc_ff <= mul_q30(33'(sr), cp);
      p_cs_ff <= mul_q30(33'(cr), sp);
      cy1_ff  <= cy;
      sy1_ff  <= sy;

      // times yaw
      t_xa_ff <= mul_q30(p_sc_ff, cy1_ff);
      t_xb_ff <= mul_q30(p_cs_ff, sy1_ff);
      t_ya_ff <= mul_q30(p_cs_ff, cy1_ff);
      t_yb_ff <= mul_q30(p_sc_ff, sy1_ff);
      t_za_ff <= mul_q30(p_cc_ff, sy1_ff);
      t_zb_ff <= mul_q30(p_ss_ff, cy1_ff);
      t_wa_ff <= mul_q30(p_cc_ff, cy1_ff);
      t_wb_ff <= mul_q30(p_ss_ff, sy1_ff);

      qx_ff <= 34'(t_xa_ff) - 34'(t_xb_ff);
      qy_ff <= 34'(t_ya_ff) + 34'(t_yb_ff);
      qz_ff <= 34'(t_za_ff) - 34'(t_zb_ff);
      qw_ff <= 34'(t_wa_ff) + 34'(t_wb_ff);

      // swapped slot order: w, y, z, x
      out_w_ff <= to_out(qw_ff);
      out_x_ff <= to_out(qy_ff);
      out_y_ff <= to_out(qz_ff);
      out_z_ff <= to_out(qx_ff);
   end

   assign valid_out   = valid_ff[PROD_STAGES-1];
   assign quat_w      = out_w_ff;
   assign quat_slot_x = out_x_ff;
   assign quat_slot_y = out_y_ff;
   assign quat_slot_z = out_z_ff;

endmodule

`default_nettype wire

@@ sv/euler_to_quaternion.sv @@
`default_nettype none

// channel   ports                                              handshake
// input     req_yaw_raw, req_pitch_raw, req_roll_raw           start & !busy
// result    rsp_quat_w, rsp_quat_slot_x/_y/_z                  rsp_valid, one cycle
//
// one item may enter every cycle and flows through the cordic cells in order
// 30 cordic cells, one register each, then four product and rounding stages
// busy is high only while reset is held; items in flight are dropped by reset
// the receiver cannot stall, so nothing inside ever holds

module euler_to_quaternion (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_yaw_raw,
   input  wire logic signed [15:0] req_pitch_raw,
   input  wire logic signed [15:0] req_roll_raw,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_quat_w,
   output logic signed [15:0]      rsp_quat_slot_x,
   output logic signed [15:0]      rsp_quat_slot_y,
   output logic signed [15:0]      rsp_quat_slot_z
);
   import e2q_pkg::*;

   logic                valid_chain [CORDIC_ITERS+1];
   e2q_lanes_type       lanes_chain [CORDIC_ITERS+1];
   logic signed [16:0]  roll_neg;

   assign busy = reset;

   // roll of -pi negates to +pi, kept in 17 bits
   assign roll_neg = -{req_roll_raw[15], req_roll_raw};

   always_comb begin
      valid_chain[0] = start && !busy;
      for (int l = 0; l < LANES; l++) begin
         lanes_chain[0][l].x = CORDIC_GAIN;
         lanes_chain[0][l].y = 32'sd0;
      end
      lanes_chain[0][LANE_YAW].z   = {{3{req_yaw_raw[15]}}, req_yaw_raw, 15'd0};
      lanes_chain[0][LANE_PITCH].z = {{3{req_pitch_raw[15]}}, req_pitch_raw, 15'd0};
      lanes_chain[0][LANE_ROLL].z  = {{2{roll_neg[16]}}, roll_neg, 15'd0};
   end

   for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
      e2q_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .idx       (5'(g)),
         .valid_in  (valid_chain[g]),
         .lanes_in  (lanes_chain[g]),
         .valid_out (valid_chain[g+1]),
         .lanes_out (lanes_chain[g+1])
      );
   end

   e2q_prod u_prod (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (valid_chain[CORDIC_ITERS]),
      .lanes_in    (lanes_chain[CORDIC_ITERS]),
      .valid_out   (rsp_valid),
      .quat_w      (rsp_quat_w),
      .quat_slot_x (rsp_quat_slot_x),
      .quat_slot_y (rsp_quat_slot_y),
      .quat_slot_z (rsp_quat_slot_z)
   );

`ifndef SYNTH
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without accepted item");

   a_w_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (OUT_FRAC_BITS > 14) ||
                    ($signed(rsp_quat_w) <= OUT_ONE && $signed(rsp_quat_w) >= -OUT_ONE))
      else $error("w outside unit range");

   a_slots_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (OUT_FRAC_BITS > 14) ||
                    ($signed(rsp_quat_slot_x) <= OUT_ONE &&
                     $signed(rsp_quat_slot_x) >= -OUT_ONE &&
                     $signed(rsp_quat_slot_y) <= OUT_ONE &&
                     $signed(rsp_quat_slot_y) >= -OUT_ONE &&
                     $signed(rsp_quat_slot_z) <= OUT_ONE &&
                     $signed(rsp_quat_slot_z) >= -OUT_ONE))
      else $error("vector slot outside unit range");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import e2q_pkg::INT_FRAC;
   import e2q_pkg::OUT_FRAC_BITS;
   import e2q_pkg::LATENCY;

   localparam int NUM_RANDOM     = 700;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam longint CORDIC_START_X = 64'sd652032874;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] slot_x;
      logic signed [15:0] slot_y;
      logic signed [15:0] slot_z;
   } quat_sample_type;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      bit                 typed;
      quat_sample_type    want;
   } angle_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_yaw_raw   = '0;
   logic signed [15:0] req_pitch_raw = '0;
   logic signed [15:0] req_roll_raw  = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_quat_w;
   logic signed [15:0] rsp_quat_slot_x;
   logic signed [15:0] rsp_quat_slot_y;
   logic signed [15:0] rsp_quat_slot_z;

   quat_sample_type quat_pending [$];
   angle_row_type   directed_rows [$];
   quat_sample_type oldest_quat;
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit steady_phase = 0;

   euler_to_quaternion DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_yaw_raw     (req_yaw_raw),
      .req_pitch_raw   (req_pitch_raw),
      .req_roll_raw    (req_roll_raw),
      .rsp_valid       (rsp_valid),
      .rsp_quat_w      (rsp_quat_w),
      .rsp_quat_slot_x (rsp_quat_slot_x),
      .rsp_quat_slot_y (rsp_quat_slot_y),
      .rsp_quat_slot_z (rsp_quat_slot_z)
   );

   always #1 clock = ~clock;

   // atan(2^-i), 2^32 = one turn
   function automatic longint atan_step(input int i);
      case (i)
         0:  return 64'h20000000;
         1:  return 64'h12E4051E;
         2:  return 64'h09FB385B;
         3:  return 64'h051111D4;
         4:  return 64'h028B0D43;
         5:  return 64'h0145D7E1;
         6:  return 64'h00A2F61E;
         7:  return 64'h00517C55;
         8:  return 64'h0028BE53;
         9:  return 64'h00145F2F;
         10: return 64'h000A2F98;
         11: return 64'h000517CC;
         12: return 64'h00028BE6;
         13: return 64'h000145F3;
         14: return 64'h0000A2FA;
         15: return 64'h0000517D;
         16: return 64'h000028BE;
         17: return 64'h0000145F;
         18: return 64'h00000A30;
         19: return 64'h00000518;
         20: return 64'h0000028C;
         21: return 64'h00000146;
         22: return 64'h000000A3;
         23: return 64'h00000051;
         24: return 64'h00000029;
         25: return 64'h00000014;
         26: return 64'h0000000A;
         27: return 64'h00000005;
         28: return 64'h00000003;
         29: return 64'h00000001;
         default: return 64'h0;
      endcase
   endfunction

   // phase: 2^17 = one turn, so the raw angle reads as its own half
   function automatic void half_angle_sincos(input longint phase, output longint c,
                                             output longint s);
      longint x, y, z, dx, dy;
      x = CORDIC_START_X;
      y = 0;
      z = phase * 32768;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(i);
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint q30_product(input longint a, input longint b);
      return (a * b + (longint'(1) <<< (INT_FRAC - 1))) >>> INT_FRAC;
   endfunction

   function automatic longint q30_triple(input longint a, input longint b, input longint c);
      return q30_product(q30_product(a, b), c);
   endfunction

   function automatic logic [15:0] to_quat_field(input longint v);
      int shift;
      longint one;
      shift = INT_FRAC - OUT_FRAC_BITS;
      one = longint'(1) <<< OUT_FRAC_BITS;
      if (shift > 0) begin
         v = (v + (longint'(1) <<< (shift - 1))) >>> shift;
      end
      if (v > one) begin
         v = one;
      end
      if (v < -one) begin
         v = -one;
      end
      return v[15:0];
   endfunction

   function automatic quat_sample_type compute_quaternion(input logic signed [15:0] yaw,
                                                          input logic signed [15:0] pitch,
                                                          input logic signed [15:0] roll);
      longint cy, sy, cp, sp, cr, sr, qw, qx, qy, qz;
      quat_sample_type q;
      half_angle_sincos(longint'(yaw), cy, sy);
      half_angle_sincos(longint'(pitch), cp, sp);
      // roll is negated, so -pi becomes +pi
      half_angle_sincos(-longint'(roll), cr, sr);
      qx = q30_triple(sr, cp, cy) - q30_triple(cr, sp, sy);
      qy = q30_triple(cr, sp, cy) + q30_triple(sr, cp, sy);
      qz = q30_triple(cr, cp, sy) - q30_triple(sr, sp, cy);
      qw = q30_triple(cr, cp, cy) + q30_triple(sr, sp, sy);
      q.w      = to_quat_field(qw);
      q.slot_x = to_quat_field(qy);
      q.slot_y = to_quat_field(qz);
      q.slot_z = to_quat_field(qx);
      return q;
   endfunction

   function automatic angle_row_type make_row(input logic signed [15:0] yaw, pitch, roll,
                                              input bit typed,
                                              input logic signed [15:0] w, sx, sy, sz);
      angle_row_type r;
      r.yaw = yaw;
      r.pitch = pitch;
      r.roll = roll;
      r.typed = typed;
      r.want.w = w;
      r.want.slot_x = sx;
      r.want.slot_y = sy;
      r.want.slot_z = sz;
      return r;
   endfunction

   function automatic logic signed [15:0] pick_angle();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd1;
            4: return 16'sd16384;
            5: return -16'sd16384;
            default: return 16'sd0;
         endcase
      end
      return 16'($urandom());
   endfunction

   // random bursts and gaps, some gaps longer than the pipeline
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         if (steady_phase) begin
            gap = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(20, 45);
         end else begin
            gap = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   task automatic send_item(input angle_row_type row);
      pace_sender();
      start <= 1'b1;
      req_yaw_raw <= row.yaw;
      req_pitch_raw <= row.pitch;
      req_roll_raw <= row.roll;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (row.typed) begin
         quat_pending.push_back(row.want);
      end else begin
         quat_pending.push_back(compute_quaternion(row.yaw, row.pitch, row.roll));
      end
   endtask

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (quat_pending.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0d %0d %0d %0d", $time,
                     rsp_quat_w, rsp_quat_slot_x, rsp_quat_slot_y, rsp_quat_slot_z);
            mismatches++;
         end else begin
            oldest_quat = quat_pending.pop_front();
            check_field("quat_w", oldest_quat.w, rsp_quat_w);
            check_field("quat_slot_x", oldest_quat.slot_x, rsp_quat_slot_x);
            check_field("quat_slot_y", oldest_quat.slot_y, rsp_quat_slot_y);
            check_field("quat_slot_z", oldest_quat.slot_z, rsp_quat_slot_z);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("euler_to_quaternion test failed");
         $finish;
      end
   end

   initial begin
      // zero angles, each angle at -pi typed in, rest computed
      directed_rows.push_back(make_row(0, 0, 0, 1, 16384, 0, 0, 0));
      directed_rows.push_back(make_row(-32768, 0, 0, 1, 0, 0, -16384, 0));
      directed_rows.push_back(make_row(0, -32768, 0, 1, 0, -16384, 0, 0));
      directed_rows.push_back(make_row(0, 0, -32768, 1, 0, 0, 0, 16384));
      directed_rows.push_back(make_row(32767, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(-1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(16384, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(-16384, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 32767, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 16384, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, -1, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 0, 32767, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 0, 16384, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(0, 0, -16384, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(32767, 32767, 32767, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(-32768, -32768, -32768, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(32767, -32768, 32767, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(-32768, 32767, -32768, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(16384, 16384, 16384, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(-1, -1, -1, 0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 100 == 0) begin
            steady_phase = ($urandom_range(0, 2) == 0);
         end
         send_item(make_row(pick_angle(), pick_angle(), pick_angle(), 0, 0, 0, 0, 0));
      end
      start <= 1'b0;

      while (quat_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (mismatches == 0) begin
         $display("euler_to_quaternion test passed");
      end else begin
         $display("euler_to_quaternion test failed");
      end
      $finish;
   end

endmodule
